// ===== rtl/core/kdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared constants and types for the key debounce / long-press block.
// ----------------------------------------------------------------------------
package kdlp_pkg;

    localparam int CODE_BITS  = 8;
    localparam int CODE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef logic [CODE_W-1:0]     code_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [1:0]            phase_t;

    // phase codes
    localparam phase_t PH_IDLE    = 2'd0;
    localparam phase_t PH_CONFIRM = 2'd1;
    localparam phase_t PH_HELD    = 2'd2;

    // register indexes
    localparam cfg_idx_t REG_DEBOUNCE   = 2'd0;
    localparam cfg_idx_t REG_LONG_PRESS = 2'd1;
    localparam cfg_idx_t REG_LOCKOUT    = 2'd2;

    // reset values and offsets
    localparam code_t DEBOUNCE_RST   = 8'd3;
    localparam code_t LONG_PRESS_RST = 8'd100;
    localparam code_t LOCKOUT_RST    = 8'd20;
    localparam code_t LONG_OFFSET    = 8'd100;

    localparam code_t CODE_MASK = code_t'((1 << CODE_BITS) - 1);

endpackage

// ===== rtl/core/key_debounce_long_press_top.sv =====
// ----------------------------------------------------------------------------
// key_debounce_long_press_top
// Debounced key scanner with short and long press events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / key_code): one request per sampled
//   tick, carrying the combined key code (0 = no key).
//   Output channel (out_valid / out_stall / event_*): exactly one result per
//   input request, in order. event_valid marks a real key event; event_code
//   and long_press are zero when no event is reported.
//   Config port (cfg_we / cfg_index / cfg_data): index 0 debounce_ticks,
//   1 long_press_ticks, 2 lockout_ticks; index 3 is ignored. Write only when
//   the block is idle (no request in flight).
// Path: an accepted request passes the input register, then the state update
//   lands in the result register.
// Throughput: one request per cycle while out_stall does not hold a full result
//   register; the phase / counter update is a single compare-and-decrement step.
// Reset: phase idle, latched code 0, counter 0, registers to 3 / 100 / 20,
//   both pipeline stages empty.
// Stall: when out_stall holds a full result register, the input register
//   keeps its request and in_stall rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module key_debounce_long_press_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  kdlp_pkg::code_t    key_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               event_valid,
    output kdlp_pkg::code_t    event_code,
    output logic               long_press,
    input  logic               cfg_we,
    input  kdlp_pkg::cfg_idx_t cfg_index,
    input  kdlp_pkg::cfg_data_t cfg_data
);
    import kdlp_pkg::*;

    // configuration
    code_t  debounce_reg, long_press_ticks_reg, lockout_reg;

    // input stage
    logic   s1_valid_reg;
    code_t  s1_code_reg;

    // block state
    phase_t phase_reg, phase_next;
    code_t  held_code_reg, held_code_next;
    code_t  delay_count_reg, delay_count_next;

    // result register
    logic   out_valid_reg;
    logic   ev_valid_reg, ev_valid_next;
    code_t  ev_code_reg, ev_code_next;
    logic   ev_long_reg, ev_long_next;

    logic   advance;
    logic   in_accept;

    // stage 1 moves into the result register when the latter is free or drains
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg         <= DEBOUNCE_RST;
            long_press_ticks_reg <= LONG_PRESS_RST;
            lockout_reg          <= LOCKOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg         <= cfg_data;
                REG_LONG_PRESS: long_press_ticks_reg <= cfg_data;
                REG_LOCKOUT:    lockout_reg          <= cfg_data;
                default:        ;
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_code_reg <= key_code & CODE_MASK;
    end

    // ---------------- phase / counter update ----------------
    always_comb
    begin
        phase_next       = phase_reg;
        held_code_next   = held_code_reg;
        delay_count_next = delay_count_reg;
        ev_valid_next    = 1'b0;
        ev_code_next     = '0;
        ev_long_next     = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                held_code_next = s1_code_reg;
                if (s1_code_reg != '0)
                begin
                    // lockout must have drained below the threshold
                    if (delay_count_reg < debounce_reg)
                    begin
                        delay_count_next = debounce_reg;
                        phase_next       = PH_CONFIRM;
                    end
                end
                else if (delay_count_reg != '0)
                    delay_count_next = delay_count_reg - 1'b1;
            end
            PH_CONFIRM:
            begin
                if (delay_count_reg != '0)
                    delay_count_next = delay_count_reg - 1'b1;
                else if (held_code_reg == s1_code_reg)
                begin
                    phase_next       = PH_HELD;
                    delay_count_next = long_press_ticks_reg;
                end
                else
                    phase_next = PH_IDLE;
            end
            PH_HELD:
            begin
                if (s1_code_reg == '0)
                begin
                    // short press on release
                    phase_next       = PH_IDLE;
                    delay_count_next = '0;
                    ev_valid_next    = 1'b1;
                    ev_code_next     = held_code_reg;
                end
                else if (delay_count_reg != '0)
                    delay_count_next = delay_count_reg - 1'b1;
                else
                begin
                    // long press: offset code wraps, lockout armed
                    delay_count_next = lockout_reg;
                    phase_next       = PH_IDLE;
                    held_code_next   = held_code_reg + LONG_OFFSET;
                    ev_valid_next    = 1'b1;
                    ev_code_next     = held_code_reg + LONG_OFFSET;
                    ev_long_next     = 1'b1;
                end
            end
            default:
                phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            held_code_reg   <= '0;
            delay_count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            held_code_reg   <= held_code_next;
            delay_count_reg <= delay_count_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ev_valid_reg <= ev_valid_next;
            ev_code_reg  <= ev_code_next;
            ev_long_reg  <= ev_long_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_valid = ev_valid_reg;
    assign event_code  = ev_code_reg;
    assign long_press  = ev_long_reg;

    // ---------------- assertions ----------------
    a_long_is_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && long_press) |-> event_valid)
        else $error("long press without event");

    a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !event_valid) |-> (event_code == '0 && !long_press))
        else $error("payload not cleared on non-event");

    a_lockout_load: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ev_long_next) |=>
            (delay_count_reg == $past(lockout_reg) && phase_reg == PH_IDLE))
        else $error("lockout not armed after long press");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> (s1_valid_reg && $stable(s1_code_reg)))
        else $error("input register lost a request");

    a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(phase_reg) && $stable(delay_count_reg)))
        else $error("state moved without a request");

endmodule
